[rtl/preamble_sync_five_bit_symbol_decoder_macros.svh]
// Assertion macros shared by the decoder RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef PREAMBLE_SYNC_FIVE_BIT_SYMBOL_DECODER_MACROS_SVH
`define PREAMBLE_SYNC_FIVE_BIT_SYMBOL_DECODER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define PSD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define PSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define PSD_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define PSD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[rtl/psd_pkg.sv]
// Package for the preamble sync five-bit symbol decoder.
// Holds shared constants, register indexes and the config struct. No dependencies.
`default_nettype none

package psd_pkg;

   localparam int MAX_PREAMBLE_DEF = 32;
   localparam int PATTERN_W        = 32;
   localparam int LENGTH_W         = 6;
   localparam int PAT_IDX_W        = 5;
   localparam int COUNT_W          = 3;
   localparam int SYMBOL_W         = 5;
   localparam int CHAR_W           = 7;
   localparam int CSR_INDEX_W      = 1;

   localparam logic [COUNT_W-1:0]   GROUP_BITS  = 3'd5;
   localparam logic [COUNT_W-1:0]   TOP_BIT     = 3'd4;
   localparam logic [CHAR_W-1:0]    CHAR_OFFSET = 7'd64;
   localparam logic [SYMBOL_W-1:0]  END_SYMBOL  = 5'd31;   // character 0x5f
   localparam logic [CHAR_W-1:0]    END_CHAR    = 7'h5f;

   localparam logic [PATTERN_W-1:0] PATTERN_RST = 32'h0000_aaaa;
   localparam logic [LENGTH_W-1:0]  LENGTH_RST  = 6'd16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN = 1'b0,
      CSR_LENGTH  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [PATTERN_W-1:0] pattern;
      logic [LENGTH_W-1:0]  length;
   } cfg_type;

endpackage

`default_nettype wire

[rtl/psd_csr.sv]
// Configuration registers: preamble pattern and length.
// Depends on psd_pkg.
`default_nettype none

module psd_csr (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [psd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [psd_pkg::PATTERN_W-1:0]    csr_data,
   output psd_pkg::cfg_type                 cfg
);
   import psd_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN: cfg_in.pattern = csr_data;
            CSR_LENGTH:  cfg_in.length  = csr_data[LENGTH_W-1:0];
            default:     cfg_in         = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern <= PATTERN_RST;
         cfg_ff.length  <= LENGTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[rtl/psd_core.sv]
// Decoder core: preamble search, 5-bit packing and the result register.
// Depends on psd_pkg.
`default_nettype none

module psd_core #(
   parameter int MAX_PREAMBLE = psd_pkg::MAX_PREAMBLE_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  psd_pkg::cfg_type             cfg,
   input  wire                          in_valid,
   input  wire                          in_bit,
   output logic                         in_take,
   output logic                         out_valid,
   output logic [psd_pkg::CHAR_W-1:0]   out_char,
   input  wire                          out_ready
);
   import psd_pkg::*;

   localparam int CAP   = (MAX_PREAMBLE < PATTERN_W) ? MAX_PREAMBLE : PATTERN_W;
   localparam int POS_W = $clog2(CAP + 1);
   localparam logic [LENGTH_W-1:0] CAP_LEN = LENGTH_W'(CAP);

   logic                 synced_ff, synced_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [SYMBOL_W-1:0]  accum_ff, accum_in;
   logic                 out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]    out_char_ff, out_char_in;

   logic [LENGTH_W-1:0]  eff_len;
   logic [POS_W-1:0]     pos_sel;
   logic [POS_W-1:0]     pos_inc;
   logic                 exp_bit;
   logic [COUNT_W-1:0]   cnt_sel;
   logic [COUNT_W-1:0]   cnt_inc;
   logic [SYMBOL_W-1:0]  acc_new;

   // slot free when the held result is empty or leaving this cycle
   assign in_take   = in_valid && (!out_valid_ff || out_ready);
   assign out_valid = out_valid_ff;
   assign out_char  = out_char_ff;

   always_comb begin
      eff_len = cfg.length;
      if (eff_len == '0)
         eff_len = LENGTH_W'(1);
      if (eff_len > CAP_LEN)
         eff_len = CAP_LEN;
   end

   always_comb begin
      pos_sel = pos_ff;
      if (LENGTH_W'(pos_ff) >= eff_len)
         pos_sel = '0;
      exp_bit = cfg.pattern[PAT_IDX_W'(pos_sel)];
      pos_inc = pos_sel + POS_W'(1);

      cnt_sel = (count_ff >= GROUP_BITS) ? '0 : count_ff;
      cnt_inc = cnt_sel + COUNT_W'(1);
      acc_new = accum_ff | (SYMBOL_W'(in_bit) << (TOP_BIT - cnt_sel));
   end

   always_comb begin
      synced_in    = synced_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      accum_in     = accum_ff;
      out_char_in  = out_char_ff;
      out_valid_in = out_valid_ff && !out_ready;
      if (in_take) begin
         if (!synced_ff) begin
            if (in_bit == exp_bit) begin
               if (LENGTH_W'(pos_inc) >= eff_len) begin
                  synced_in = 1'b1;
                  pos_in    = '0;
                  count_in  = '0;
                  accum_in  = '0;
               end else begin
                  pos_in = pos_inc;
               end
            end else if (in_bit == cfg.pattern[0]) begin
               pos_in = POS_W'(1);
            end else begin
               pos_in = '0;
            end
         end else if (cnt_inc < GROUP_BITS) begin
            count_in = cnt_inc;
            accum_in = acc_new;
         end else begin
            count_in = '0;
            accum_in = '0;
            if (acc_new == END_SYMBOL) begin
               synced_in = 1'b0;
            end else begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_OFFSET + CHAR_W'(acc_new);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         synced_ff    <= 1'b0;
         pos_ff       <= '0;
         count_ff     <= '0;
         accum_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         synced_ff    <= synced_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         accum_ff     <= accum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_char_ff <= out_char_in;
   end

endmodule

`default_nettype wire

[rtl/preamble_sync_five_bit_symbol_decoder.sv]
// Preamble sync five-bit symbol decoder, top level.
// A req bit passes the input register and then the core result register before rsp_tvalid rises.
// Throughput: one bit per cycle while rsp_tready holds.
// A five-bit group gives at most one rsp transfer every fifth accepted bit.
// Reset (synchronous, high): searching for preamble, pattern 0xAAAA, length 16, both regs empty.
`include "preamble_sync_five_bit_symbol_decoder_macros.svh"
`default_nettype none

module preamble_sync_five_bit_symbol_decoder #(
   parameter int MAX_PREAMBLE = psd_pkg::MAX_PREAMBLE_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   // input bit stream
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [7:0]                        req_tdata,   // [0] in_bit, [7:1] zero
   // decoded characters
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [7:0]                        rsp_tdata,   // [6:0] symbol_char, [7] zero
   // configuration writes
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [psd_pkg::CSR_INDEX_W-1:0]   csr_index,   // 0 pattern, 1 length
   input  wire  [psd_pkg::PATTERN_W-1:0]     csr_data
);
   import psd_pkg::*;

   cfg_type              cfg;
   logic                 in_valid_ff, in_valid_in;
   logic                 in_bit_ff, in_bit_in;
   logic                 core_take;
   logic                 core_valid;
   logic [CHAR_W-1:0]    core_char;

   psd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Input register: refills in the same cycle the core takes the held bit.
   assign req_tready = !in_valid_ff || core_take;

   always_comb begin
      in_valid_in = in_valid_ff && !core_take;
      in_bit_in   = in_bit_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_bit_in   = req_tdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_bit_ff <= in_bit_in;
   end

   // Search / pack state and the result register live in the core.
   psd_core #(
      .MAX_PREAMBLE (MAX_PREAMBLE)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (in_valid_ff),
      .in_bit    (in_bit_ff),
      .in_take   (core_take),
      .out_valid (core_valid),
      .out_char  (core_char),
      .out_ready (rsp_tready)
   );

   assign rsp_tvalid = core_valid;
   assign rsp_tdata  = {1'b0, core_char};

   // end-of-message group never leaves as a character
   `PSD_ASSERT_IMPL(a_no_end_char, clock, reset, rsp_tvalid, rsp_tdata[6:0] != END_CHAR)
   // every character carries the offset bit
   `PSD_ASSERT_IMPL(a_char_offset, clock, reset, rsp_tvalid, rsp_tdata[6] == 1'b1)
   // a new result only follows a core take
   `PSD_ASSERT_NEXT(a_result_source, clock, reset, !rsp_tvalid && !core_take, !rsp_tvalid)
   // an empty input register never stalls the stream
   `PSD_ASSERT_IMPL(a_in_ready, clock, reset, !in_valid_ff, req_tready)

endmodule

`default_nettype wire

[tb/psd_char_checker.sv]
// Checker for the preamble sync five-bit symbol decoder: watches all three channels,
// predicts the decoded characters and compares them in order with the rsp transfers.
// Depends on psd_pkg for register indexes, widths and decoder constants.
module psd_char_checker #(
   parameter int MAX_PREAMBLE = psd_pkg::MAX_PREAMBLE_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   input  wire                          req_tready,
   input  wire  [7:0]                   req_tdata,    // [0] in_bit, [7:1] zero
   input  wire                          rsp_tvalid,
   input  wire                          rsp_tready,
   input  wire  [7:0]                   rsp_tdata,    // [6:0] symbol_char, [7] zero
   input  wire                          csr_valid,
   input  wire                          csr_ready,
   input  psd_pkg::csr_index_type       csr_index,
   input  wire  [psd_pkg::PATTERN_W-1:0] csr_data,
   output int                           fail_count,
   output int                           chars_pending,
   output int                           chars_checked,
   output int                           sync_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import psd_pkg::*;

   localparam int LEN_CAP = (MAX_PREAMBLE < 32) ? MAX_PREAMBLE : 32;

   // shadow registers and decoder state
   logic [PATTERN_W-1:0] pattern_q;
   logic [LENGTH_W-1:0]  length_q;
   logic                 synced_q;
   logic [LENGTH_W-1:0]  match_pos_q;
   logic [COUNT_W-1:0]   group_cnt_q;
   logic [SYMBOL_W-1:0]  group_bits_q;

   logic [CHAR_W-1:0]    expected_chars[$];
   int                   errors = 0;
   int                   checked = 0;
   int                   syncs = 0;

   function automatic logic [LENGTH_W-1:0] effective_len(input logic [LENGTH_W-1:0] raw);
      if (raw == '0) return 6'd1;
      if (raw > LEN_CAP) return LENGTH_W'(LEN_CAP);
      return raw;
   endfunction

   // one accepted bit: search for the preamble, or pack into the current group
   task automatic decode_bit(input logic b);
      logic [LENGTH_W-1:0] len;
      logic [LENGTH_W-1:0] pos;
      logic [CHAR_W-1:0]   ch;
      if (!synced_q) begin
         len = effective_len(length_q);
         pos = match_pos_q;
         // length lowered mid-search: start over
         if (pos >= len) pos = '0;
         if (b == pattern_q[pos[PAT_IDX_W-1:0]]) begin
            pos = pos + 1'b1;
            if (pos >= len) begin
               synced_q     = 1'b1;
               pos          = '0;
               group_cnt_q  = '0;
               group_bits_q = '0;
               syncs++;
            end
         end else if (b == pattern_q[0]) begin
            pos = 6'd1;
         end else begin
            pos = '0;
         end
         match_pos_q = pos;
      end else begin
         if (group_cnt_q >= GROUP_BITS) group_cnt_q = '0;
         group_bits_q = group_bits_q | (SYMBOL_W'(b) << (TOP_BIT - group_cnt_q));
         group_cnt_q  = group_cnt_q + 1'b1;
         if (group_cnt_q == GROUP_BITS) begin
            ch           = CHAR_W'(group_bits_q) + CHAR_OFFSET;
            group_cnt_q  = '0;
            group_bits_q = '0;
            // end group drops sync silently
            if (ch == END_CHAR) synced_q = 1'b0;
            else expected_chars.push_back(ch);
         end
      end
   endtask

   always @(posedge clock) begin
      logic [CHAR_W-1:0] want;
      if (reset) begin
         pattern_q    = PATTERN_RST;
         length_q     = LENGTH_RST;
         synced_q     = 1'b0;
         match_pos_q  = '0;
         group_cnt_q  = '0;
         group_bits_q = '0;
         expected_chars.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PATTERN) pattern_q = csr_data;
            else length_q = csr_data[LENGTH_W-1:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected character, expected none actual %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_tdata !== {1'b0, want}) begin
                  $display("%0t: character mismatch, expected %h actual %h",
                           $time, {1'b0, want}, rsp_tdata);
                  errors++;
               end
               checked++;
            end
         end
         if (req_tvalid && req_tready) decode_bit(req_tdata[0]);
      end
      fail_count    <= errors;
      chars_pending <= expected_chars.size();
      chars_checked <= checked;
      sync_count    <= syncs;
   end

endmodule

[tb/tb_preamble_sync_five_bit_symbol_decoder.sv]
// Testbench top for the preamble sync five-bit symbol decoder: clock, reset, bit stimulus,
// register programming, receiver stalls, watchdog and verdict.
// Depends on psd_pkg, the decoder RTL and psd_char_checker.
module tb_preamble_sync_five_bit_symbol_decoder;
   timeunit 1ns;
   timeprecision 1ps;
   import psd_pkg::*;

   localparam int TOTAL_ITEMS    = 1900;
   localparam int HOLD_CYCLES    = 8;     // margin for in-flight bits
   localparam int WATCHDOG_LIMIT = 1000;  // quiet cycles before the run is stopped
   localparam int LEN_CAP        = (MAX_PREAMBLE_DEF < 32) ? MAX_PREAMBLE_DEF : 32;

   typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_CHOPPY} rx_mode_type;
   typedef enum int {FRAME_CLEAN, FRAME_BROKEN, FRAME_NOISE} frame_kind_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   wire                  req_tready;
   logic [7:0]           req_tdata = '0;   // [0] in_bit, [7:1] zero
   wire                  rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   wire  [7:0]           rsp_tdata;        // [6:0] symbol_char, [7] zero
   logic                 csr_valid = 1'b0;
   wire                  csr_ready;
   csr_index_type        csr_index = CSR_PATTERN;
   logic [PATTERN_W-1:0] csr_data = '0;

   int fail_count;
   int chars_pending;
   int chars_checked;
   int sync_count;

   // stimulus-side view of the programmed registers
   logic [PATTERN_W-1:0] cur_pattern = PATTERN_RST;
   logic [LENGTH_W-1:0]  cur_length  = LENGTH_RST;

   int items_sent    = 0;
   int burst_left    = 0;
   int config_writes = 0;
   int phases        = 0;

   preamble_sync_five_bit_symbol_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   psd_char_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .chars_pending (chars_pending),
      .chars_checked (chars_checked),
      .sync_count    (sync_count)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver: picks a random stall mode and holds it for a random stretch; open mode gives stall-free stretches.
   rx_mode_type rx_mode   = RX_OPEN;
   int          mode_left = 0;
   int          stall_left = 0;
   always @(posedge clock) begin
      if (mode_left == 0) begin
         rx_mode   = rx_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(50, 400);
      end else begin
         mode_left--;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         case (rx_mode)
            RX_LIGHT:  if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
            RX_HEAVY:  if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(4, 16);
            RX_CHOPPY: if ($urandom_range(0, 1) == 0) stall_left = 1;
            default: ;
         endcase
      end
   end

   // Watchdog: any transfer on any channel restarts the count.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d characters outstanding",
                  $time, quiet_cycles, chars_pending);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One bit transfer. Bursts of random length, random gaps between them;
   // now and then a long burst so there are stretches without idling.
   task automatic send_bit(input logic b);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, b};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   // five bits, MSB first
   task automatic send_group(input logic [SYMBOL_W-1:0] value);
      for (int i = SYMBOL_W - 1; i >= 0; i--) send_bit(value[i]);
   endtask

   // preamble as programmed; broken flips one bit
   task automatic send_preamble(input logic broken);
      int len;
      int flip;
      len  = (cur_length == 0) ? 1 : ((cur_length > LEN_CAP) ? LEN_CAP : int'(cur_length));
      flip = broken ? $urandom_range(0, len - 1) : -1;
      for (int k = 0; k < len; k++) send_bit(cur_pattern[k] ^ (k == flip));
   endtask

   // Pause the sender until every predicted character has come back, then
   // let bits that give no character clear the pipeline.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (chars_pending != 0) @(posedge clock);
      repeat (HOLD_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [PATTERN_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_PATTERN) cur_pattern = value;
      else cur_length = value[LENGTH_W-1:0];
      config_writes++;
   endtask

   // Only called while idle. Order of the two writes is random; valid stays
   // high across back-to-back writes and drops once at the end.
   task automatic apply_config(input logic wr_pat, input logic [PATTERN_W-1:0] pat_val,
                               input logic wr_len, input logic [PATTERN_W-1:0] len_val);
      logic pat_first;
      pat_first = $urandom_range(0, 1);
      if (wr_pat && pat_first) write_reg(CSR_PATTERN, pat_val);
      if (wr_len) write_reg(CSR_LENGTH, len_val);
      if (wr_pat && !pat_first) write_reg(CSR_PATTERN, pat_val);
      csr_valid <= 1'b0;
      phases++;
   endtask

   initial begin
      logic [PATTERN_W-1:0] pat;
      logic [LENGTH_W-1:0]  len;
      int                   pick;
      frame_kind_type       kind;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // length zero acts as one; upper data bits of the length write are dropped
      apply_config(1'b1, 32'h0000_0001, 1'b1, 32'hffff_ffc0);
      send_bit(1'b1);              // single-bit preamble, enters sync
      send_group(5'd0);            // lowest character
      send_group(5'd30);           // highest character
      send_group(END_SYMBOL);      // end group, back to search
      drain();
      // search position left beyond a lowered length
      apply_config(1'b1, 32'h0000_0000, 1'b1, 32'd8);
      repeat (4) send_bit(1'b0);
      drain();
      apply_config(1'b0, '0, 1'b1, 32'd2);
      repeat (2) send_bit(1'b0);   // restarts from zero, then syncs
      send_group(5'b10101);
      drain();

      // --- random phases ---
      while (items_sent < TOTAL_ITEMS) begin
         case ($urandom_range(0, 5))
            0:       pat = '0;
            1:       pat = '1;
            2:       pat = 32'h5555_5555;
            default: pat = $urandom();
         endcase
         case ($urandom_range(0, 9))
            0:       len = 6'd0;
            1:       len = 6'd1;
            2:       len = 6'd32;
            3:       len = LENGTH_W'($urandom_range(33, 63));   // saturates
            4, 5:    len = LENGTH_W'($urandom_range(1, 4));
            default: len = LENGTH_W'($urandom_range(2, 20));
         endcase
         pick = $urandom_range(0, 3);
         apply_config(pick != 1, pat, pick != 0,
                      ($urandom() & ~32'h3f) | PATTERN_W'(len));

         repeat ($urandom_range(2, 8)) begin
            pick = $urandom_range(0, 9);
            kind = (pick < 7) ? FRAME_CLEAN : ((pick < 9) ? FRAME_BROKEN : FRAME_NOISE);
            case (kind)
               FRAME_CLEAN: begin
                  send_preamble(1'b0);
                  repeat ($urandom_range(0, 6)) send_group(SYMBOL_W'($urandom()));
                  if ($urandom_range(0, 4) != 0) send_group(END_SYMBOL);
               end
               FRAME_BROKEN: begin
                  send_preamble(1'b1);
                  repeat ($urandom_range(0, 12)) send_bit($urandom_range(0, 1));
               end
               default: begin
                  repeat ($urandom_range(1, 20)) send_bit($urandom_range(0, 1));
               end
            endcase
         end
         drain();
      end

      drain();
      $display("Run covered %0d bits over %0d register settings (%0d writes), %0d syncs,",
               items_sent, phases, config_writes, sync_count);
      $display("with %0d decoded characters checked in order.", chars_checked);
      if (fail_count == 0 && chars_pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
